// ===== src/assert_macros.svh =====
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, skipped while in reset
`define AES_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aes assertion failed");

// clocked implication checked in the next cycle
`define AES_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes assertion failed");

`endif

// ===== src/aes_pkg.sv =====
// aes-128 constants, s-box and round functions
`default_nettype none
package aes_pkg;

    localparam int BLK_W     = 128;
    localparam int HALF_W    = 64;
    localparam int NUM_ROUND = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef logic [BLK_W-1:0] block_t;
    typedef logic [7:0] byte_t;

    localparam byte_t RCON [NUM_ROUND] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
        8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
        8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
        8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
        8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
        8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
        8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
        8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
        8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
        8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
        8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
        8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
        8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
        8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
        8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
        8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
        8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
        8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
        8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
        8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
        8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
        8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
        8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
        8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
        8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
        8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
        8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
        8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
        8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
        8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
    };

    // byte i of a block, byte 0 in the top bits
    function automatic byte_t get_byte(input block_t b, input int i);
        return b[BLK_W-1-8*i -: 8];
    endfunction

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // subbytes and shiftrows together
    function automatic block_t sub_shift(input block_t s);
        block_t n;
        n = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                n[BLK_W-1-8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
            end
        end
        return n;
    endfunction

    function automatic block_t mix_cols(input block_t s);
        block_t n;
        byte_t  a0, a1, a2, a3, all;
        n = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0  = get_byte(s, c*4);
            a1  = get_byte(s, c*4+1);
            a2  = get_byte(s, c*4+2);
            a3  = get_byte(s, c*4+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            n[BLK_W-1-8*(c*4)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            n[BLK_W-1-8*(c*4+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            n[BLK_W-1-8*(c*4+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            n[BLK_W-1-8*(c*4+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return n;
    endfunction

    // one step of the key schedule
    function automatic block_t next_key(input block_t k, input byte_t rc);
        logic [31:0] t, w0, w1, w2, w3;
        t  = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
              SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// ===== src/aes_stream_if.sv =====
// plaintext and ciphertext channel interfaces
`default_nettype none
interface aes_plain_if;
    logic        valid;
    logic        ready;
    logic [63:0] plaintext_high;
    logic [63:0] plaintext_low;

    modport source (output valid, output plaintext_high, output plaintext_low, input ready);
    modport sink (input valid, input plaintext_high, input plaintext_low, output ready);
endinterface

interface aes_cipher_if;
    logic        valid;
    logic        ready;
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;

    modport source (output valid, output ciphertext_high, output ciphertext_low, input ready);
    modport sink (input valid, input ciphertext_high, input ciphertext_low, output ready);
endinterface
`default_nettype wire

// ===== src/aes_round_cell.sv =====
// one aes round cell: round key step and state round, registered
`default_nettype none
module aes_round_cell
    import aes_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   last,
    input  wire byte_t  rcon,
    input  wire logic   valid_in,
    input  wire block_t state_in,
    input  wire block_t key_in,
    output logic        valid_reg,
    output block_t      state_reg,
    output block_t      key_reg
);

    block_t key_next;
    block_t sub_st;
    block_t state_next;

    // round datapath
    always_comb
    begin
        key_next   = next_key(key_in, rcon);
        sub_st     = sub_shift(state_in);
        state_next = (last ? sub_st : mix_cols(sub_st)) ^ key_next;
    end

    // valid bit of this cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/aes128_block_encrypt.sv =====
// aes-128 encryption top level: key registers and chain of round cells
//
// channel  dir  payload                           handshake
// plain    in   plaintext_high, plaintext_low     valid/ready
// cipher   out  ciphertext_high, ciphertext_low   valid/ready
// cfg      in   cfg_index, cfg_data               cfg_we
//
// one block accepted per cycle while the chain is not stalled; the result passes through
// the input add-key stage and ten round cells (eleven register stages)
// the whole chain advances together; it stalls only when the result
// register is full and the sink is not ready
// reset clears the key registers and all stage valid bits
`default_nettype none
`include "assert_macros.svh"
module aes128_block_encrypt
    import aes_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [HALF_W-1:0]    cfg_data,
    aes_plain_if.sink                 plain,
    aes_cipher_if.source              cipher
);

    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;
    logic              en;
    logic              valid_s [NUM_ROUND+1];
    block_t            state_s [NUM_ROUND+1];
    block_t            key_s   [NUM_ROUND+1];

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // chain advance
    assign en          = !valid_s[NUM_ROUND] || cipher.ready;
    assign plain.ready = en;

    // input stage: initial add-key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_s[0] <= 1'b0;
        else if (en)
            valid_s[0] <= plain.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_s[0] <= {plain.plaintext_high, plain.plaintext_low}
                          ^ {key_high_reg, key_low_reg};
            key_s[0]   <= {key_high_reg, key_low_reg};
        end
    end

    // round cells
    for (genvar i = 1; i <= NUM_ROUND; i++)
    begin : g_round
        aes_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .last      (i == NUM_ROUND),
            .rcon      (RCON[i-1]),
            .valid_in  (valid_s[i-1]),
            .state_in  (state_s[i-1]),
            .key_in    (key_s[i-1]),
            .valid_reg (valid_s[i]),
            .state_reg (state_s[i]),
            .key_reg   (key_s[i])
        );
    end

    // result
    assign cipher.valid           = valid_s[NUM_ROUND];
    assign cipher.ciphertext_high = state_s[NUM_ROUND][BLK_W-1:HALF_W];
    assign cipher.ciphertext_low  = state_s[NUM_ROUND][HALF_W-1:0];

    // checks
    `AES_ASSERT_NXT(a_in_to_first, plain.valid && plain.ready, valid_s[0])
    `AES_ASSERT_IMP(a_stall_blocks_in, cipher.valid && !cipher.ready, !plain.ready)
    `AES_ASSERT_NXT(a_last_shift, en, cipher.valid == $past(valid_s[NUM_ROUND-1]))
    `AES_ASSERT_NXT(a_hold_on_stall, !en, $stable(cipher.ciphertext_low) && cipher.valid)

endmodule
`default_nettype wire

// ===== bench/aes128_cipher_scoreboard.sv =====
// scoreboard class for aes-128 encryption: predicts ciphertext and checks results
`timescale 1ns / 100ps
class aes128_cipher_scoreboard;
    logic [63:0]  key_high;
    logic [63:0]  key_low;
    logic [127:0] cipher_queue[$];
    int           mismatch_count;

    function void reset_key();
        key_high       = '0;
        key_low        = '0;
        cipher_queue   = {};
        mismatch_count = 0;
    endfunction

    // byte i of a block, byte 0 in the top bits
    function logic [7:0] blk_byte(logic [127:0] b, int i);
        return b[127-8*i -: 8];
    endfunction

    function logic [7:0] dbl(logic [7:0] a);
        logic [7:0] d;
        d = {a[6:0], 1'b0};
        if (a[7])
        begin
            d = d ^ 8'h1B;
        end
        return d;
    endfunction

    // full encryption of one block under the current key
    function logic [127:0] encrypt(logic [127:0] pt);
        logic [127:0] rkey;
        logic [127:0] st;
        logic [127:0] nx;
        logic [31:0]  t;
        logic [31:0]  w0;
        logic [31:0]  w1;
        logic [31:0]  w2;
        logic [31:0]  w3;
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        logic [7:0]   sum;
        rkey = {key_high, key_low};
        st   = pt ^ rkey;
        for (int rnd = 1; rnd <= aes_pkg::NUM_ROUND; rnd++)
        begin
            // substitute and rotate rows
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    nx[127-8*(c*4+r) -: 8] = aes_pkg::SBOX[blk_byte(st, ((c+r)&3)*4 + r)];
                end
            end
            st = nx;
            // column mixing, skipped in the last round
            if (rnd != aes_pkg::NUM_ROUND)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0  = blk_byte(st, c*4);
                    a1  = blk_byte(st, c*4+1);
                    a2  = blk_byte(st, c*4+2);
                    a3  = blk_byte(st, c*4+3);
                    sum = a0 ^ a1 ^ a2 ^ a3;
                    nx[127-8*(c*4)   -: 8] = a0 ^ sum ^ dbl(a0 ^ a1);
                    nx[127-8*(c*4+1) -: 8] = a1 ^ sum ^ dbl(a1 ^ a2);
                    nx[127-8*(c*4+2) -: 8] = a2 ^ sum ^ dbl(a2 ^ a3);
                    nx[127-8*(c*4+3) -: 8] = a3 ^ sum ^ dbl(a3 ^ a0);
                end
                st = nx;
            end
            // next round key
            t  = {aes_pkg::SBOX[blk_byte(rkey, 13)] ^ aes_pkg::RCON[rnd-1],
                  aes_pkg::SBOX[blk_byte(rkey, 14)], aes_pkg::SBOX[blk_byte(rkey, 15)],
                  aes_pkg::SBOX[blk_byte(rkey, 12)]};
            w0   = rkey[127:96] ^ t;
            w1   = rkey[95:64] ^ w0;
            w2   = rkey[63:32] ^ w1;
            w3   = rkey[31:0] ^ w2;
            rkey = {w0, w1, w2, w3};
            st   = st ^ rkey;
        end
        return st;
    endfunction

    function void note_plaintext(logic [63:0] hi, logic [63:0] lo);
        cipher_queue.push_back(encrypt({hi, lo}));
    endfunction

    function void check_ciphertext(logic [63:0] hi, logic [63:0] lo);
        logic [127:0] want;
        if (cipher_queue.size() == 0)
        begin
            $display("%0t: unexpected ciphertext %h %h", $time, hi, lo);
            mismatch_count++;
            return;
        end
        want = cipher_queue.pop_front();
        if (want[127:64] !== hi)
        begin
            $display("%0t: ciphertext_high expected %h actual %h", $time, want[127:64], hi);
            mismatch_count++;
        end
        if (want[63:0] !== lo)
        begin
            $display("%0t: ciphertext_low expected %h actual %h", $time, want[63:0], lo);
            mismatch_count++;
        end
    endfunction
endclass

// ===== bench/aes128_block_encrypt_test.sv =====
// top-level testbench for aes128_block_encrypt: directed and random block traffic
`timescale 1ns / 100ps
module aes128_block_encrypt_test;
    import aes_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PIPE_DRAIN     = 20;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HALF_W-1:0]    cfg_data;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   idle_cycles;
    bit                   timed_out;

    aes_plain_if  plain ();
    aes_cipher_if cipher ();

    aes128_cipher_scoreboard sb;

    aes128_block_encrypt dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .plain     (plain),
        .cipher    (cipher)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sample transactions at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (plain.valid && plain.ready)
            begin
                sb.note_plaintext(plain.plaintext_high, plain.plaintext_low);
            end
            if (cipher.valid && cipher.ready)
            begin
                sb.check_ciphertext(cipher.ciphertext_high, cipher.ciphertext_low);
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        cipher.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (plain.valid && plain.ready) || (cipher.valid && cipher.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("** aes128_block_encrypt: FAILED **");
            $finish;
        end
    end

    task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_KEY_HIGH)
        begin
            sb.key_high = val;
        end
        else
        begin
            sb.key_low = val;
        end
    endtask

    task automatic load_key(logic [63:0] hi, logic [63:0] lo);
        write_key(REG_KEY_HIGH, hi);
        write_key(REG_KEY_LOW, lo);
    endtask

    // one plaintext transaction, valid held until accepted; valid drops only
    // in idle cycles or at drain, so back-to-back transactions keep it high
    task automatic send_block(logic [63:0] hi, logic [63:0] lo);
        while ($urandom_range(99) < send_idle_pct)
        begin
            plain.valid <= 1'b0;
            @(negedge clk);
        end
        plain.valid          <= 1'b1;
        plain.plaintext_high <= hi;
        plain.plaintext_low  <= lo;
        do
        begin
            @(posedge clk);
        end
        while (!plain.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        plain.valid <= 1'b0;
        while (sb.cipher_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random blocks, mostly random data with some all-zero, all-one or one-hot halves
    task automatic send_random(int n);
        logic [63:0] hi;
        logic [63:0] lo;
        for (int i = 0; i < n; i++)
        begin
            hi = rand64();
            lo = rand64();
            case ($urandom_range(9))
                0: hi = '0;
                1: lo = '1;
                2: begin hi = 64'd1 << $urandom_range(63); lo = '0; end
                default: ;
            endcase
            send_block(hi, lo);
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_key();
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_KEY_HIGH;
        cfg_data             = '0;
        plain.valid          = 1'b0;
        plain.plaintext_high = '0;
        plain.plaintext_low  = '0;
        cipher.ready         = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        idle_cycles          = 0;
        timed_out            = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key still in use before any write
        send_block('0, '0);
        send_block('1, '1);
        drain();

        // standard test vector key and plaintext
        load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block('0, '1);
        send_block('1, '0);
        for (int b = 0; b < 8; b++)
        begin
            send_block(64'h8000000000000000 >> (b * 8), 64'h0000000000000001 << (b * 8));
        end
        drain();

        // out-of-range index cannot be expressed: single-bit index covers both registers
        load_key('1, '1);
        send_block('0, '0);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_block('1, '1);
        drain();
        load_key('0, '1);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();

        // random phases under varied idling and keys
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (ph == 4)
            begin
                load_key('0, '0);
            end
            else
            begin
                load_key(rand64(), rand64());
            end
            send_random(68);
            drain();
        end

        if (sb.mismatch_count == 0 && sb.cipher_queue.size() == 0)
        begin
            $display("** aes128_block_encrypt: PASSED **");
        end
        else
        begin
            $display("** aes128_block_encrypt: FAILED **");
        end
        $finish;
    end
endmodule
